### rtl/lpzc_pkg.sv
// Package for the LiDAR protective-zone classifier.
// Holds shared widths, command, zone and register codes, reset values and the
// configuration struct. Depends on nothing.
package lpzc_pkg;

  // Default values for the top-level parameters.
  localparam int unsigned LPZC_COORD_WIDTH = 16;
  localparam int unsigned LPZC_SPEED_BANDS = 4;
  localparam int unsigned LPZC_QUEUE_DEPTH = 4;

  localparam int unsigned VEL_W      = 16;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned BAND_W     = 2;
  // Danger extension and radius in millimetres (255 cm * 10).
  localparam int unsigned DIST_W     = 12;

  typedef enum logic [1:0] {
    CMD_SPEED  = 2'd0,
    CMD_POINT  = 2'd1,
    CMD_EMPTY  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ZONE_CLEAR   = 2'd0,
    ZONE_CAUTION = 2'd1,
    ZONE_DANGER  = 2'd2
  } zone_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VEHICLE_LENGTH = 3'd0,
    REG_VEHICLE_WIDTH  = 3'd1,
    REG_REAR_OFFSET    = 3'd2,
    REG_CAUTION_FRONT  = 3'd3,
    REG_CAUTION_SIDE   = 3'd4,
    REG_CAUTION_REAR   = 3'd5,
    REG_CAUTION_RADIUS = 3'd6,
    REG_DANGER_TABLE   = 3'd7
  } reg_e;

  // Squared speed thresholds: 300, 1000 and 2000 mm/s.
  localparam logic [31:0] BAND_THR [3] = '{32'd90000, 32'd1000000, 32'd4000000};

  typedef struct packed {
    logic        [12:0] vehicle_length;
    logic        [12:0] vehicle_width;
    logic signed [12:0] rear_offset;
    logic        [12:0] caution_front_ext;
    logic        [11:0] caution_side_ext;
    logic signed [13:0] caution_rear_ext;
    logic        [12:0] caution_radius;
  } zone_cfg_t;

  localparam logic [12:0] RST_VEHICLE_LENGTH = 13'd1100;
  localparam logic [12:0] RST_VEHICLE_WIDTH  = 13'd700;
  localparam logic [12:0] RST_REAR_OFFSET    = 13'h1F9C;
  localparam logic [12:0] RST_CAUTION_FRONT  = 13'd2000;
  localparam logic [11:0] RST_CAUTION_SIDE   = 12'd500;
  localparam logic [13:0] RST_CAUTION_REAR   = 14'h3C18;
  localparam logic [12:0] RST_CAUTION_RADIUS = 13'd800;
  localparam logic [CFG_DATA_W-1:0] RST_DANGER_TABLE = 64'h509646783C3C320A;

endpackage

### rtl/lidar_protective_zone_classifier.sv
// LiDAR protective-zone classifier. Each request is a speed sample, a cluster
// point or an empty-cluster marker; a point is tested against a danger zone and
// a caution zone (a rectangle around the vehicle plus a disc in front of it),
// and at the last point of a cluster, or on an empty cluster, one result gives
// 2 for danger, 1 for caution and 0 for clear, with the speed band in use. The
// block sustains one request per clock in both directions when nothing stalls.
// A request passes a front-end register (velocity squares, band choice, danger
// table lookup), a four-entry queue, a three-stage back end (bounds, squares,
// disc compare) and an output register. Configuration registers are written
// through their own port, one register per request; the user must write them
// only while the block is idle, which the block itself does not enforce.
//
// Files: lpzc_pkg, lpzc_front, lpzc_queue, lpzc_back.
module lidar_protective_zone_classifier #(
  parameter int unsigned COORD_WIDTH = lpzc_pkg::LPZC_COORD_WIDTH,
  parameter int unsigned SPEED_BANDS = lpzc_pkg::LPZC_SPEED_BANDS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lpzc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lpzc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Input requests.
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          cmd_i,
  input  logic signed [COORD_WIDTH-1:0]       x_mm_i,
  input  logic signed [COORD_WIDTH-1:0]       y_mm_i,
  input  logic signed [lpzc_pkg::VEL_W-1:0]   vel_x_mm_s_i,
  input  logic signed [lpzc_pkg::VEL_W-1:0]   vel_y_mm_s_i,
  input  logic                                last_i,
  // Results.
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          zone_flag_o,
  output logic [lpzc_pkg::BAND_W-1:0]         speed_band_o
);
  import lpzc_pkg::*;

  // Queue entry: point flag, last flag, band, danger extension and radius, x, y.
  localparam int unsigned ENTRY_W = 2 + BAND_W + 2 * DIST_W + 2 * COORD_WIDTH;

  zone_cfg_t             cfg_q;
  logic [CFG_DATA_W-1:0] danger_table_q;

  logic                          push_valid, push_ready, pop_valid, pop_ready;
  logic [ENTRY_W-1:0]            push_data, pop_data;
  logic                          f_is_point, f_last, b_is_point, b_last;
  logic signed [COORD_WIDTH-1:0] f_x, f_y, b_x, b_y;
  logic [BAND_W-1:0]             f_band, b_band;
  logic [DIST_W-1:0]             f_dfront, f_drad, b_dfront, b_drad;

  // Takes writes every cycle; the user must write only while the block is idle
  // so no request sees a half-updated configuration; the block does not check.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vehicle_length    <= RST_VEHICLE_LENGTH;
      cfg_q.vehicle_width     <= RST_VEHICLE_WIDTH;
      cfg_q.rear_offset       <= RST_REAR_OFFSET;
      cfg_q.caution_front_ext <= RST_CAUTION_FRONT;
      cfg_q.caution_side_ext  <= RST_CAUTION_SIDE;
      cfg_q.caution_rear_ext  <= RST_CAUTION_REAR;
      cfg_q.caution_radius    <= RST_CAUTION_RADIUS;
      danger_table_q          <= RST_DANGER_TABLE;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_VEHICLE_LENGTH: cfg_q.vehicle_length    <= cfg_data_i[12:0];
        REG_VEHICLE_WIDTH:  cfg_q.vehicle_width     <= cfg_data_i[12:0];
        REG_REAR_OFFSET:    cfg_q.rear_offset       <= cfg_data_i[12:0];
        REG_CAUTION_FRONT:  cfg_q.caution_front_ext <= cfg_data_i[12:0];
        REG_CAUTION_SIDE:   cfg_q.caution_side_ext  <= cfg_data_i[11:0];
        REG_CAUTION_REAR:   cfg_q.caution_rear_ext  <= cfg_data_i[13:0];
        REG_CAUTION_RADIUS: cfg_q.caution_radius    <= cfg_data_i[12:0];
        REG_DANGER_TABLE:   danger_table_q          <= cfg_data_i;
        default:            danger_table_q          <= danger_table_q;
      endcase
    end
  end

  // Front end: speed samples only move the band register; points and empty
  // clusters leave with the band and danger geometry they must be judged by,
  // so a speed change mid-cluster takes effect for the very next point.
  lpzc_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .SPEED_BANDS (SPEED_BANDS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .x_mm_i          (x_mm_i),
    .y_mm_i          (y_mm_i),
    .vel_x_mm_s_i    (vel_x_mm_s_i),
    .vel_y_mm_s_i    (vel_y_mm_s_i),
    .last_i          (last_i),
    .danger_table_i  (danger_table_q),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_is_point_o (f_is_point),
    .push_last_o     (f_last),
    .push_x_o        (f_x),
    .push_y_o        (f_y),
    .push_band_o     (f_band),
    .push_dfront_o   (f_dfront),
    .push_drad_o     (f_drad)
  );

  assign push_data = {f_is_point, f_last, f_band, f_dfront, f_drad, f_x, f_y};

  // The queue lets the front keep taking requests while the back end waits
  // on the result consumer.
  lpzc_queue #(
    .DATA_W (ENTRY_W),
    .DEPTH  (LPZC_QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign {b_is_point, b_last, b_band, b_dfront, b_drad, b_x, b_y} = pop_data;

  // Back end: zone tests and per-cluster flag accumulation.
  lpzc_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .is_point_i   (b_is_point),
    .last_i       (b_last),
    .x_i          (b_x),
    .y_i          (b_y),
    .band_i       (b_band),
    .dfront_i     (b_dfront),
    .drad_i       (b_drad),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .zone_flag_o  (zone_flag_o),
    .speed_band_o (speed_band_o)
  );

endmodule

### rtl/lpzc_front.sv
// Front end of the zone classifier: input register, speed squaring, speed band
// tracking and danger-table lookup. Resolved requests go to the queue.
// Depends on lpzc_pkg.
module lpzc_front #(
  parameter int unsigned COORD_WIDTH = lpzc_pkg::LPZC_COORD_WIDTH,
  parameter int unsigned SPEED_BANDS = lpzc_pkg::LPZC_SPEED_BANDS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            cmd_i,
  input  logic signed [COORD_WIDTH-1:0]         x_mm_i,
  input  logic signed [COORD_WIDTH-1:0]         y_mm_i,
  input  logic signed [lpzc_pkg::VEL_W-1:0]     vel_x_mm_s_i,
  input  logic signed [lpzc_pkg::VEL_W-1:0]     vel_y_mm_s_i,
  input  logic                                  last_i,
  input  logic [lpzc_pkg::CFG_DATA_W-1:0]       danger_table_i,
  output logic                                  push_valid_o,
  input  logic                                  push_ready_i,
  output logic                                  push_is_point_o,
  output logic                                  push_last_o,
  output logic signed [COORD_WIDTH-1:0]         push_x_o,
  output logic signed [COORD_WIDTH-1:0]         push_y_o,
  output logic [lpzc_pkg::BAND_W-1:0]           push_band_o,
  output logic [lpzc_pkg::DIST_W-1:0]           push_dfront_o,
  output logic [lpzc_pkg::DIST_W-1:0]           push_drad_o
);
  import lpzc_pkg::*;

  logic                          f1_valid_q, f1_valid_d;
  cmd_e                          f1_cmd_q;
  logic signed [COORD_WIDTH-1:0] f1_x_q, f1_y_q;
  logic                          f1_last_q;
  logic [2*VEL_W-2:0]            f1_vx2_q, f1_vy2_q;
  logic [BAND_W-1:0]             band_q, band_d;

  logic signed [2*VEL_W-1:0]     vx_prod, vy_prod;
  logic [2*VEL_W-1:0]            speed2;
  logic [BAND_W-1:0]             band_new;
  logic                          f1_is_speed, f1_done, in_accept;
  logic [15:0]                   entry;

  assign vx_prod = vel_x_mm_s_i * vel_x_mm_s_i;
  assign vy_prod = vel_y_mm_s_i * vel_y_mm_s_i;

  assign f1_is_speed  = (f1_cmd_q == CMD_SPEED);
  // A speed sample retires here; points and empty clusters need queue room.
  assign f1_done      = f1_is_speed || push_ready_i;
  assign in_ready_o   = !f1_valid_q || f1_done;
  assign in_accept    = in_valid_i && in_ready_o;
  assign push_valid_o = f1_valid_q && !f1_is_speed;

  always_comb begin
    if (in_accept) begin
      f1_valid_d = (cmd_e'(cmd_i) != CMD_UNUSED);
    end else if (f1_done) begin
      f1_valid_d = 1'b0;
    end else begin
      f1_valid_d = f1_valid_q;
    end
  end

  assign speed2 = {1'b0, f1_vx2_q} + {1'b0, f1_vy2_q};

  always_comb begin
    band_new = '0;
    for (int i = 0; i < 3; i++) begin
      if ((i + 1 < SPEED_BANDS) && (speed2 >= BAND_THR[i])) begin
        band_new = BAND_W'(i + 1);
      end
    end
  end

  always_comb begin
    band_d = band_q;
    if (f1_valid_q && f1_is_speed) begin
      band_d = band_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      band_q     <= '0;
    end else begin
      f1_valid_q <= f1_valid_d;
      band_q     <= band_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      f1_cmd_q  <= cmd_e'(cmd_i);
      f1_x_q    <= x_mm_i;
      f1_y_q    <= y_mm_i;
      f1_last_q <= last_i;
      f1_vx2_q  <= vx_prod[2*VEL_W-2:0];
      f1_vy2_q  <= vy_prod[2*VEL_W-2:0];
    end
  end

  // Table entries are in centimetres; scale to millimetres.
  assign entry           = danger_table_i[{band_q, 4'b0000} +: 16];
  assign push_dfront_o   = DIST_W'(entry[7:0]) * DIST_W'(10);
  assign push_drad_o     = DIST_W'(entry[15:8]) * DIST_W'(10);
  assign push_is_point_o = (f1_cmd_q == CMD_POINT);
  assign push_last_o     = f1_last_q;
  assign push_x_o        = f1_x_q;
  assign push_y_o        = f1_y_q;
  assign push_band_o     = band_q;

endmodule

### rtl/lpzc_queue.sv
// Small register queue between the front and back ends of the classifier.
// Generic data width and depth; no package content beyond the default depth.
module lpzc_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = lpzc_pkg::LPZC_QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/lpzc_back.sv
// Back end of the zone classifier: three-stage geometry pipeline (bounds and
// rectangle tests, squares, disc compare), cluster flags and output register.
// Depends on lpzc_pkg.
module lpzc_back #(
  parameter int unsigned COORD_WIDTH = lpzc_pkg::LPZC_COORD_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lpzc_pkg::zone_cfg_t               cfg_i,
  input  logic                              pop_valid_i,
  output logic                              pop_ready_o,
  input  logic                              is_point_i,
  input  logic                              last_i,
  input  logic signed [COORD_WIDTH-1:0]     x_i,
  input  logic signed [COORD_WIDTH-1:0]     y_i,
  input  logic [lpzc_pkg::BAND_W-1:0]       band_i,
  input  logic [lpzc_pkg::DIST_W-1:0]       dfront_i,
  input  logic [lpzc_pkg::DIST_W-1:0]       drad_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        zone_flag_o,
  output logic [lpzc_pkg::BAND_W-1:0]       speed_band_o
);
  import lpzc_pkg::*;

  localparam int unsigned CMP_W = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 2;
  localparam int unsigned DX_W  = CMP_W - 2;
  localparam int unsigned SQ_W  = 2 * DX_W + 1;
  localparam int unsigned RC_W  = 13;

  // Stage 1: raw request from the queue.
  logic                          b1_valid_q, b1_valid_d;
  logic                          b1_is_point_q, b1_last_q;
  logic signed [COORD_WIDTH-1:0] b1_x_q, b1_y_q;
  logic [BAND_W-1:0]             b1_band_q;
  logic [DIST_W-1:0]             b1_dfront_q, b1_drad_q;

  // Stage 2: rectangle results and disc offsets.
  logic                          b2_valid_q, b2_valid_d;
  logic                          b2_is_point_q, b2_last_q;
  logic [BAND_W-1:0]             b2_band_q;
  logic                          b2_rect_d_q, b2_rect_c_q, b2_beyond_d_q, b2_beyond_c_q;
  logic [DX_W-1:0]               b2_dx_d_q, b2_dx_c_q;
  logic [COORD_WIDTH-1:0]        b2_ay_q;
  logic [DIST_W-1:0]             b2_drad_q;

  // Stage 3: squares.
  logic                          b3_valid_q, b3_valid_d;
  logic                          b3_is_point_q, b3_last_q;
  logic [BAND_W-1:0]             b3_band_q;
  logic                          b3_rect_d_q, b3_rect_c_q, b3_beyond_d_q, b3_beyond_c_q;
  logic [2*DX_W-1:0]             b3_sq_d_q, b3_sq_c_q;
  logic [2*COORD_WIDTH-1:0]      b3_ysq_q;
  logic [2*DIST_W-1:0]           b3_rd2_q;
  logic [2*RC_W-1:0]             b3_rc2_q;

  logic                          danger_q, danger_d, caution_q, caution_d;
  logic                          out_valid_q, out_valid_d;
  zone_e                         zone_q, zone_new;
  logic [BAND_W-1:0]             out_band_q;

  logic b1_ready, b2_ready, b3_ready, b3_fire, b3_result, out_free;

  // Stage 1 to 2 geometry.
  logic signed [CMP_W-1:0] x_e, y_e, y2, roff, front_base, front_d, front_c, rear_c;
  logic signed [CMP_W-1:0] w2_d, w2_c, dx_d, dx_c, ay;
  logic                    rect_d, rect_c, beyond_d, beyond_c;

  // Stage 3 compare.
  logic [2*DX_W-1:0]        sq_d, sq_c;
  logic [2*COORD_WIDTH-1:0] ysq;
  logic [2*DIST_W-1:0]      rd2;
  logic [2*RC_W-1:0]        rc2;
  logic [SQ_W-1:0]          dist_d, dist_c;
  logic                     hit_d, hit_c, danger_acc, caution_acc;

  // Handshake between stages.
  assign out_free    = !out_valid_q || out_ready_i;
  assign b3_result   = !b3_is_point_q || b3_last_q;
  assign b3_fire     = b3_valid_q && (!b3_result || out_free);
  assign b3_ready    = !b3_valid_q || b3_fire;
  assign b2_ready    = !b2_valid_q || b3_ready;
  assign b1_ready    = !b1_valid_q || b2_ready;
  assign pop_ready_o = b1_ready;

  always_comb begin
    b1_valid_d = b1_ready ? pop_valid_i : b1_valid_q;
    b2_valid_d = b2_ready ? b1_valid_q  : b2_valid_q;
    b3_valid_d = b3_ready ? b2_valid_q  : b3_valid_q;
  end

  // Zone bounds. The half width is never formed: 2y is compared with the width.
  always_comb begin
    x_e        = CMP_W'(b1_x_q);
    y_e        = CMP_W'(b1_y_q);
    y2         = y_e <<< 1;
    roff       = CMP_W'(cfg_i.rear_offset);
    front_base = roff + $signed(CMP_W'(cfg_i.vehicle_length));
    front_d    = front_base + $signed(CMP_W'(b1_dfront_q));
    front_c    = front_base + $signed(CMP_W'(cfg_i.caution_front_ext));
    rear_c     = roff - CMP_W'(cfg_i.caution_rear_ext);
    w2_d       = $signed(CMP_W'(cfg_i.vehicle_width));
    w2_c       = w2_d + $signed(CMP_W'({cfg_i.caution_side_ext, 1'b0}));
    rect_d     = (x_e >= roff) && (x_e <= front_d) && (y2 >= -w2_d) && (y2 <= w2_d);
    rect_c     = (x_e >= rear_c) && (x_e <= front_c) && (y2 >= -w2_c) && (y2 <= w2_c);
    beyond_d   = (x_e >= front_d);
    beyond_c   = (x_e >= front_c);
    dx_d       = x_e - front_d;
    dx_c       = x_e - front_c;
    ay         = (y_e < 0) ? -y_e : y_e;
  end

  assign sq_d = b2_dx_d_q * b2_dx_d_q;
  assign sq_c = b2_dx_c_q * b2_dx_c_q;
  assign ysq  = b2_ay_q * b2_ay_q;
  assign rd2  = b2_drad_q * b2_drad_q;
  assign rc2  = cfg_i.caution_radius * cfg_i.caution_radius;

  always_comb begin
    dist_d = SQ_W'(b3_sq_d_q) + SQ_W'(b3_ysq_q);
    dist_c = SQ_W'(b3_sq_c_q) + SQ_W'(b3_ysq_q);
    hit_d  = b3_rect_d_q || (b3_beyond_d_q && (dist_d <= SQ_W'(b3_rd2_q)));
    hit_c  = b3_rect_c_q || (b3_beyond_c_q && (dist_c <= SQ_W'(b3_rc2_q)));
  end

  // Cluster flags: danger wins and freezes the cluster; caution only counts
  // while no danger hit has been seen.
  always_comb begin
    danger_acc  = danger_q;
    caution_acc = caution_q;
    if (b3_is_point_q && !danger_q) begin
      if (hit_d) begin
        danger_acc = 1'b1;
      end else if (hit_c) begin
        caution_acc = 1'b1;
      end
    end
    danger_d  = danger_q;
    caution_d = caution_q;
    if (b3_fire) begin
      danger_d  = b3_result ? 1'b0 : danger_acc;
      caution_d = b3_result ? 1'b0 : caution_acc;
    end
    if (danger_acc) begin
      zone_new = ZONE_DANGER;
    end else if (caution_acc) begin
      zone_new = ZONE_CAUTION;
    end else begin
      zone_new = ZONE_CLEAR;
    end
    if (b3_fire && b3_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      b3_valid_q  <= 1'b0;
      danger_q    <= 1'b0;
      caution_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      b1_valid_q  <= b1_valid_d;
      b2_valid_q  <= b2_valid_d;
      b3_valid_q  <= b3_valid_d;
      danger_q    <= danger_d;
      caution_q   <= caution_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_valid_i && b1_ready) begin
      b1_is_point_q <= is_point_i;
      b1_last_q     <= last_i;
      b1_x_q        <= x_i;
      b1_y_q        <= y_i;
      b1_band_q     <= band_i;
      b1_dfront_q   <= dfront_i;
      b1_drad_q     <= drad_i;
    end
    if (b1_valid_q && b2_ready) begin
      b2_is_point_q <= b1_is_point_q;
      b2_last_q     <= b1_last_q;
      b2_band_q     <= b1_band_q;
      b2_rect_d_q   <= rect_d;
      b2_rect_c_q   <= rect_c;
      b2_beyond_d_q <= beyond_d;
      b2_beyond_c_q <= beyond_c;
      b2_dx_d_q     <= dx_d[DX_W-1:0];
      b2_dx_c_q     <= dx_c[DX_W-1:0];
      b2_ay_q       <= ay[COORD_WIDTH-1:0];
      b2_drad_q     <= b1_drad_q;
    end
    if (b2_valid_q && b3_ready) begin
      b3_is_point_q <= b2_is_point_q;
      b3_last_q     <= b2_last_q;
      b3_band_q     <= b2_band_q;
      b3_rect_d_q   <= b2_rect_d_q;
      b3_rect_c_q   <= b2_rect_c_q;
      b3_beyond_d_q <= b2_beyond_d_q;
      b3_beyond_c_q <= b2_beyond_c_q;
      b3_sq_d_q     <= sq_d;
      b3_sq_c_q     <= sq_c;
      b3_ysq_q      <= ysq;
      b3_rd2_q      <= rd2;
      b3_rc2_q      <= rc2;
    end
    if (b3_fire && b3_result) begin
      zone_q     <= zone_new;
      out_band_q <= b3_band_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign zone_flag_o  = zone_q;
  assign speed_band_o = out_band_q;

endmodule

### bench/testbench.sv
// Self-checking testbench for the LiDAR protective-zone classifier.
// Drives speed samples, cluster points and empty-cluster markers under random
// flow control and checks every result against an internal zone predictor.
// Depends on lpzc_pkg and the lidar_protective_zone_classifier RTL.
`timescale 1ns / 100ps

module testbench;
  import lpzc_pkg::*;

  localparam int CW          = LPZC_COORD_WIDTH;
  localparam int SPEED_BANDS = LPZC_SPEED_BANDS;

  // Squared speed limits of the bands: 300, 1000 and 2000 mm/s.
  localparam longint SLOW_SQ = 90000;
  localparam longint MID_SQ  = 1000000;
  localparam longint FAST_SQ = 4000000;

  // The drain pause lets the block finish with margin before any register write.
  localparam int DRAIN_PAD      = 16;
  localparam int END_PAD        = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 30;

  typedef struct packed {
    zone_e      zone;
    logic [1:0] band;
  } zone_result_t;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst_ni;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stimulus side of the block.
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_cmd;
  logic signed [CW-1:0] in_x;
  logic signed [CW-1:0] in_y;
  logic signed [VEL_W-1:0] in_vx;
  logic signed [VEL_W-1:0] in_vy;
  logic                 in_last;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           zone_flag;
  logic [BAND_W-1:0]    speed_band;

  lidar_protective_zone_classifier u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .cmd_i        (in_cmd),
    .x_mm_i       (in_x),
    .y_mm_i       (in_y),
    .vel_x_mm_s_i (in_vx),
    .vel_y_mm_s_i (in_vy),
    .last_i       (in_last),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .zone_flag_o  (zone_flag),
    .speed_band_o (speed_band)
  );

  // Predictor copy of the configuration and of the cluster state.
  zone_cfg_t       zone_cfg;
  logic [63:0]     danger_tab;
  logic [1:0]      band_now;
  bit              danger_now;
  bit              caution_now;
  zone_result_t    expected_results[$];

  // Bookkeeping shared by the tasks and the monitors.
  int  err_count       = 0;
  int  req_count       = 0;
  int  results_checked = 0;
  int  reg_writes      = 0;
  int  input_stalls    = 0;
  int  burst_left      = 0;
  bit  gaps_on         = 1'b1;
  bit  hold_request    = 1'b0;
  int  hold_left       = 0;
  logic [15:0] rx_pattern;
  logic [3:0]  rx_phase = '0;

  // ---------------------------------------------------------------------------
  // Zone predictor
  // ---------------------------------------------------------------------------

  // Front extension and disc radius of the danger zone for the band in use.
  // The table holds centimetres; the zone works in millimetres.
  function automatic longint danger_front_mm();
    return longint'(danger_tab[16*band_now +: 8]) * 10;
  endfunction

  function automatic longint danger_radius_mm();
    return longint'(danger_tab[16*band_now + 8 +: 8]) * 10;
  endfunction

  // A zone is the rectangle rear..front along x with |2y| <= span2, plus a
  // disc centered on the front edge at y = 0. Every limit is inclusive, and
  // the disc only counts at or beyond the front edge.
  function automatic bit in_zone(input longint px, py, rear, front, span2, radius);
    longint dx;
    if (rear <= px && px <= front && -span2 <= 2*py && 2*py <= span2) begin
      return 1'b1;
    end
    if (px >= front) begin
      dx = px - front;
      return dx*dx + py*py <= radius*radius;
    end
    return 1'b0;
  endfunction

  // Applies one accepted request to the predictor and queues the result that
  // it must cause, if any.
  task automatic classify_request(input cmd_e c, input longint px, py, vx, vy,
                                  input bit last);
    longint       speed_sq;
    longint       len;
    longint       wid;
    longint       roff;
    zone_result_t res;
    len  = longint'(zone_cfg.vehicle_length);
    wid  = longint'(zone_cfg.vehicle_width);
    roff = longint'($signed(zone_cfg.rear_offset));
    case (c)
      CMD_SPEED: begin
        speed_sq = vx*vx + vy*vy;
        if (speed_sq >= FAST_SQ) begin
          band_now = 2'd3;
        end else if (speed_sq >= MID_SQ) begin
          band_now = 2'd2;
        end else if (speed_sq >= SLOW_SQ) begin
          band_now = 2'd1;
        end else begin
          band_now = 2'd0;
        end
        if (band_now > SPEED_BANDS - 1) begin
          band_now = 2'(SPEED_BANDS - 1);
        end
      end
      CMD_POINT: begin
        // Once a cluster has reached the danger zone nothing can change it.
        if (!danger_now) begin
          if (in_zone(px, py, roff, roff + len + danger_front_mm(), wid,
                      danger_radius_mm())) begin
            danger_now = 1'b1;
          end else if (in_zone(px, py,
                               roff - longint'($signed(zone_cfg.caution_rear_ext)),
                               roff + len + longint'(zone_cfg.caution_front_ext),
                               wid + 2*longint'(zone_cfg.caution_side_ext),
                               longint'(zone_cfg.caution_radius))) begin
            caution_now = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    if (c == CMD_EMPTY || (c == CMD_POINT && last)) begin
      res.zone = danger_now ? ZONE_DANGER : (caution_now ? ZONE_CAUTION : ZONE_CLEAR);
      res.band = band_now;
      expected_results = {expected_results, res};
      danger_now  = 1'b0;
      caution_now = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request and register drivers. All of them start and end at a falling edge.
  // ---------------------------------------------------------------------------

  // Offers one request and holds it until the block takes it. The sender runs
  // in bursts; between bursts valid drops for a random number of cycles.
  task automatic send_request(input cmd_e c, input int px, py, vx, vy,
                              input bit last);
    if (gaps_on && burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    in_valid = 1'b1;
    in_cmd   = c;
    in_x     = CW'(px);
    in_y     = CW'(py);
    in_vx    = VEL_W'(vx);
    in_vy    = VEL_W'(vy);
    in_last  = last;
    @(posedge clk);
    while (!in_ready) begin
      input_stalls++;
      @(posedge clk);
    end
    classify_request(c, longint'(in_x), longint'(in_y), longint'(in_vx),
                     longint'(in_vy), last);
    if (c != CMD_UNUSED) begin
      req_count++;
    end
    @(negedge clk);
  endtask

  // Drops valid and waits until every expected result has come out, then lets
  // the pipeline run dry of requests that make no result.
  task automatic wait_idle(input int pad);
    in_valid = 1'b0;
    while (expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (pad) @(negedge clk);
  endtask

  task automatic write_reg(input reg_e idx, input logic [63:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    case (idx)
      REG_VEHICLE_LENGTH: zone_cfg.vehicle_length    = value[12:0];
      REG_VEHICLE_WIDTH:  zone_cfg.vehicle_width     = value[12:0];
      REG_REAR_OFFSET:    zone_cfg.rear_offset       = value[12:0];
      REG_CAUTION_FRONT:  zone_cfg.caution_front_ext = value[12:0];
      REG_CAUTION_SIDE:   zone_cfg.caution_side_ext  = value[11:0];
      REG_CAUTION_REAR:   zone_cfg.caution_rear_ext  = value[13:0];
      REG_CAUTION_RADIUS: zone_cfg.caution_radius    = value[12:0];
      REG_DANGER_TABLE:   danger_tab                 = value;
      default: begin
      end
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Writes the whole register set. Signed values go in masked to their width.
  task automatic write_all_regs(input int len, wid, roff, c_front, c_side, c_rear,
                                c_rad, input logic [63:0] table_bits);
    write_reg(REG_VEHICLE_LENGTH, 64'(len) & 64'h1FFF);
    write_reg(REG_VEHICLE_WIDTH,  64'(wid) & 64'h1FFF);
    write_reg(REG_REAR_OFFSET,    64'(roff) & 64'h1FFF);
    write_reg(REG_CAUTION_FRONT,  64'(c_front) & 64'h1FFF);
    write_reg(REG_CAUTION_SIDE,   64'(c_side) & 64'h0FFF);
    write_reg(REG_CAUTION_REAR,   64'(c_rear) & 64'h3FFF);
    write_reg(REG_CAUTION_RADIUS, 64'(c_rad) & 64'h1FFF);
    write_reg(REG_DANGER_TABLE,   table_bits);
  endtask

  // ---------------------------------------------------------------------------
  // Random stimulus
  // ---------------------------------------------------------------------------

  function automatic int any_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Most x values land on or next to a zone limit for the current settings,
  // since that is where a wrong compare shows up.
  function automatic int pick_x();
    longint roff;
    longint front;
    longint mark;
    roff  = longint'($signed(zone_cfg.rear_offset));
    front = roff + longint'(zone_cfg.vehicle_length);
    case ($urandom_range(0, 7))
      0: return any_coord();
      1, 2: return int'($urandom_range(0, 30000)) - 10000;
      default: begin
        case ($urandom_range(0, 5))
          0: mark = roff;
          1: mark = front + danger_front_mm();
          2: mark = front + danger_front_mm() + danger_radius_mm();
          3: mark = roff - longint'($signed(zone_cfg.caution_rear_ext));
          4: mark = front + longint'(zone_cfg.caution_front_ext);
          default: mark = front + longint'(zone_cfg.caution_front_ext)
                          + longint'(zone_cfg.caution_radius);
        endcase
        return int'(mark) + int'($urandom_range(0, 6)) - 3;
      end
    endcase
  endfunction

  function automatic int pick_y();
    int half;
    int mark;
    half = int'(zone_cfg.vehicle_width) / 2;
    case ($urandom_range(0, 7))
      0: return any_coord();
      1, 2: return int'($urandom_range(0, 24000)) - 12000;
      default: begin
        case ($urandom_range(0, 4))
          0: mark = 0;
          1: mark = half;
          2: mark = half + int'(zone_cfg.caution_side_ext);
          3: mark = int'(danger_radius_mm());
          default: mark = int'(zone_cfg.caution_radius);
        endcase
        mark = mark + int'($urandom_range(0, 4)) - 2;
        return $urandom_range(0, 1) ? -mark : mark;
      end
    endcase
  endfunction

  // Speeds cluster around the band limits, with some slow and some wild ones.
  task automatic send_speed_sample();
    int vx;
    int vy;
    int lim;
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 2))
          0: lim = 300;
          1: lim = 1000;
          default: lim = 2000;
        endcase
        lim = lim + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1)) lim = -lim;
        if ($urandom_range(0, 1)) begin
          vx = lim;
          vy = 0;
        end else begin
          vx = 0;
          vy = lim;
        end
      end
      1: begin
        vx = int'($urandom_range(0, 5000)) - 2500;
        vy = int'($urandom_range(0, 5000)) - 2500;
      end
      2: begin
        vx = any_coord();
        vy = any_coord();
      end
      default: begin
        vx = 0;
        vy = 0;
      end
    endcase
    send_request(CMD_SPEED, any_coord(), any_coord(), vx, vy,
                 1'($urandom_range(0, 1)));
  endtask

  task automatic send_point(input bit last);
    send_request(CMD_POINT, pick_x(), pick_y(), any_coord(), any_coord(), last);
  endtask

  // Mostly well-formed clusters with random content; the rest is noise such
  // as stray empty markers, unused commands and points with a random last.
  task automatic send_random_traffic(input int count);
    int start;
    int npts;
    int pick;
    start = req_count;
    while (req_count - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 1)) send_speed_sample();
        npts = $urandom_range(1, 6);
        for (int i = 0; i < npts; i++) begin
          // A speed change inside a cluster applies to the points after it.
          if ($urandom_range(0, 15) == 0) send_speed_sample();
          send_point(i == npts - 1);
        end
      end else if (pick < 78) begin
        send_request(CMD_EMPTY, any_coord(), any_coord(), any_coord(), any_coord(),
                     1'($urandom_range(0, 1)));
      end else if (pick < 86) begin
        send_request(CMD_UNUSED, any_coord(), any_coord(), any_coord(), any_coord(),
                     1'($urandom_range(0, 1)));
      end else if (pick < 94) begin
        send_speed_sample();
      end else begin
        send_point(1'($urandom_range(0, 1)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: danger box x -100..1100, |y| <= 350, disc 500 mm; caution
  // box x 900..3000, |y| <= 850, disc 800 mm. Points sit on both sides of the
  // limits, and every command and band shows up.
  task automatic test_directed_defaults();
    send_request(CMD_EMPTY, 0, 0, 0, 0, 1'b0);
    send_request(CMD_POINT, 0, 0, 0, 0, 1'b1);
    send_request(CMD_POINT, 1100, 350, 0, 0, 1'b1);
    send_request(CMD_POINT, 1600, 0, 0, 0, 1'b1);
    send_request(CMD_POINT, 1601, 0, 0, 0, 1'b1);
    send_request(CMD_POINT, 3000, 850, 0, 0, 1'b1);
    send_request(CMD_POINT, 3800, 0, 0, 0, 1'b1);
    send_request(CMD_POINT, 3801, 0, 0, 0, 1'b1);
    send_request(CMD_POINT, -101, 0, 0, 0, 1'b1);
    // An empty marker in the middle of a cluster reports what was gathered.
    send_request(CMD_POINT, 1700, 0, 0, 0, 1'b0);
    send_request(CMD_EMPTY, 0, 0, 0, 0, 1'b0);
    // The band switches in the middle of a cluster and widens the danger zone.
    send_request(CMD_POINT, 1601, 0, 0, 0, 1'b0);
    send_request(CMD_SPEED, 0, 0, 2000, 0, 1'b0);
    send_request(CMD_POINT, 1601, 0, 0, 0, 1'b1);
    send_request(CMD_SPEED, 0, 0, 299, 0, 1'b0);
    // The unused command must leave no trace, even with every bit set.
    send_request(CMD_UNUSED, -1, -1, -1, -1, 1'b1);
    send_request(CMD_EMPTY, 0, 0, 0, 0, 1'b1);
    send_request(CMD_SPEED, 0, 0, 300, 0, 1'b0);
    send_request(CMD_EMPTY, 0, 0, 0, 0, 1'b0);
    send_request(CMD_SPEED, 0, 0, 0, -1000, 1'b0);
    send_request(CMD_EMPTY, 0, 0, 0, 0, 1'b0);
    send_request(CMD_SPEED, 0, 0, -32768, -32768, 1'b0);
    send_request(CMD_POINT, 32767, 32767, 0, 0, 1'b0);
    send_request(CMD_POINT, -32768, -32768, 0, 0, 1'b1);
    send_request(CMD_SPEED, 0, 0, 0, 0, 1'b0);
  endtask

  // Every register at its top value, then its bottom value, then a mixed set.
  // The bottom set turns the caution box inside out; only its disc can hit.
  task automatic test_register_extremes();
    wait_idle(DRAIN_PAD);
    write_all_regs(8191, 8191, 4095, 8191, 4095, 8191, 8191, '1);
    send_random_traffic(40);
    wait_idle(DRAIN_PAD);
    write_all_regs(0, 0, -4096, 0, 0, -8192, 0, '0);
    send_random_traffic(40);
    wait_idle(DRAIN_PAD);
    write_all_regs(900, 600, 0, 1000, 300, -8192, 2500, 64'h7FFF_3C80_12C8_0101);
    send_random_traffic(30);
  endtask

  // Several settings in the range a real vehicle would use.
  task automatic test_random_settings();
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle(DRAIN_PAD);
      write_all_regs($urandom_range(0, 4000), $urandom_range(0, 3000),
                     int'($urandom_range(0, 4000)) - 2000, $urandom_range(0, 5000),
                     $urandom_range(0, 2000), int'($urandom_range(0, 6000)) - 3000,
                     $urandom_range(0, 3000), {$urandom, $urandom});
      send_random_traffic(40);
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // requests back to back, so the queue fills and the input stalls.
  task automatic test_back_pressure();
    wait_idle(DRAIN_PAD);
    write_all_regs(1100, 700, -100, 2000, 500, -1000, 800, RST_DANGER_TABLE);
    gaps_on      = 1'b0;
    hold_request = 1'b1;
    send_random_traffic(60);
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver and checker
  // ---------------------------------------------------------------------------

  // Ready follows a 16-bit pattern that is redrawn each time it runs out;
  // some patterns never stall. A hold request overrides it.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES - 1;
      out_ready    = 1'b0;
    end else begin
      if (rx_phase == 4'd0) begin
        case ($urandom_range(0, 3))
          0: rx_pattern = 16'hFFFF;
          1: rx_pattern = 16'($urandom);
          default: rx_pattern = 16'($urandom | $urandom);
        endcase
      end
      out_ready = rx_pattern[rx_phase];
      rx_phase  = rx_phase + 4'd1;
    end
  end

  // Each result taken is matched against the oldest expected one.
  always @(posedge clk) begin
    zone_result_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS) begin
          $display("%0t: result with nothing pending, zone_flag %0d speed_band %0d",
                   $time, zone_flag, speed_band);
        end
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (zone_flag !== want.zone) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("%0t: zone_flag expected %0d actual %0d", $time, want.zone,
                     zone_flag);
          end
        end
        if (speed_band !== want.band) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("%0t: speed_band expected %0d actual %0d", $time, want.band,
                     speed_band);
          end
        end
      end
    end
  end

  // Watchdog: ends the run if no channel moves a request for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
             WATCHDOG_LIMIT, expected_results.size());
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_cmd     = CMD_SPEED;
    in_x       = '0;
    in_y       = '0;
    in_vx      = '0;
    in_vy      = '0;
    in_last    = 1'b0;
    out_ready  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_VEHICLE_LENGTH;
    cfg_data   = '0;
    rx_pattern = 16'hFFFF;
    zone_cfg   = '{RST_VEHICLE_LENGTH, RST_VEHICLE_WIDTH, RST_REAR_OFFSET,
                   RST_CAUTION_FRONT, RST_CAUTION_SIDE, RST_CAUTION_REAR,
                   RST_CAUTION_RADIUS};
    danger_tab  = RST_DANGER_TABLE;
    band_now    = 2'd0;
    danger_now  = 1'b0;
    caution_now = 1'b0;
    burst_left  = $urandom_range(1, 30);

    repeat (4) @(negedge clk);
    rst_ni = 1'b1;

    test_directed_defaults();
    test_register_extremes();
    test_random_settings();
    test_back_pressure();
    wait_idle(END_PAD);

    $display("Covered %0d requests and %0d results over %0d register writes,",
             req_count, results_checked, reg_writes);
    $display("with reset, extreme and random settings; input stalled %0d cycles.",
             input_stalls);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", err_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
